// ----- design/dsc_pkg.sv -----
// Shared types and constants for the directional scan cursor.
// Used by the channel interfaces and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

    // Store size defaults
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 128;

    // Field widths of the request and result channels
    localparam int REQ_TYPE_W = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int HUE_W      = 3;

    // Internal coordinate width, covers any store size up to 256
    localparam int CRD_W      = 8;

    // Configuration port
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    localparam logic [6:0] GRID_ROWS_RST = 7'd64;
    localparam logic [7:0] GRID_COLS_RST = 8'd128;

    typedef enum logic [1:0] {
        REG_DIR  = 2'd0,
        REG_ROWS = 2'd1,
        REG_COLS = 2'd2,
        REG_FILL = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_TICK    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        DIR_DIAG_TL   = 3'd0,
        DIR_ROWS_DOWN = 3'd1,
        DIR_DIAG_TR   = 3'd2,
        DIR_COLS_LEFT = 3'd3,
        DIR_DIAG_BR   = 3'd4,
        DIR_ROWS_UP   = 3'd5,
        DIR_DIAG_BL   = 3'd6,
        DIR_COLS_RIGHT = 3'd7
    } t_dir;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PUSH
    } t_state;

    typedef struct packed {
        logic [CRD_W-1:0] row;
        logic [CRD_W-1:0] col;
    } t_pos;

    typedef struct packed {
        t_pos pos;
        logic wrap;
    } t_step;

    typedef struct packed {
        logic             painted_valid;
        logic [ROW_W-1:0] painted_row;
        logic [COL_W-1:0] painted_col;
        logic [HUE_W-1:0] painted_hue;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_col;
        logic             scan_wrapped;
    } t_res;

endpackage

`default_nettype wire

// ----- design/dsc_req_if.sv -----
// Request channel: valid/ready handshake with load, tick and restart payload.
// Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dsc_req_if;
    import dsc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [ROW_W-1:0]      cell_row;
    logic [COL_W-1:0]      cell_col;
    logic                  cell_inked;

    modport source (output valid, output req_type, output cell_row, output cell_col,
                    output cell_inked, input ready);
    modport sink   (input valid, input req_type, input cell_row, input cell_col,
                    input cell_inked, output ready);
endinterface

`default_nettype wire

// ----- design/dsc_res_if.sv -----
// Result channel: valid/ready handshake with paint and cursor report.
// Depends on dsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dsc_res_if;
    import dsc_pkg::*;

    logic             valid;
    logic             ready;
    logic             painted_valid;
    logic [ROW_W-1:0] painted_row;
    logic [COL_W-1:0] painted_col;
    logic [HUE_W-1:0] painted_hue;
    logic [ROW_W-1:0] cursor_row;
    logic [COL_W-1:0] cursor_col;
    logic             scan_wrapped;

    modport source (output valid, output painted_valid, output painted_row,
                    output painted_col, output painted_hue, output cursor_row,
                    output cursor_col, output scan_wrapped, input ready);
    modport sink   (input valid, input painted_valid, input painted_row,
                    input painted_col, input painted_hue, input cursor_row,
                    input cursor_col, input scan_wrapped, output ready);
endinterface

`default_nettype wire

// ----- design/directional_scan_cursor.sv -----
// Directional scan cursor: one request at a time; each produces exactly one result.
// A load, restart or unused request is accepted in the idle state and then handed to
// the output register from the push state. A tick that paints also passes through the
// scan state, which reads the ink map while skipping blanks (none with fill-all set),
// because every candidate cell is checked through the single read port of the ink map,
// one cell per cycle. After reset the ink map is cleared by a pass over all
// 2**(clog2(MAX_ROWS)+clog2(MAX_COLS)) entries (8192 at the defaults), during
// which no request is taken; register writes are taken at any time.
// Depends on dsc_pkg, dsc_req_if, dsc_res_if.
`timescale 1ns / 1ps
`default_nettype none

module directional_scan_cursor #(
    parameter int MAX_ROWS = dsc_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = dsc_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    dsc_req_if.sink                      i_req,
    dsc_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import dsc_pkg::*;

    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = 2 ** AW;
    localparam logic [8:0] MAXR9 = 9'(MAX_ROWS);
    localparam logic [8:0] MAXC9 = 9'(MAX_COLS);

    // Configuration registers
    t_dir       r_dir;
    logic [6:0] r_grid_rows;
    logic [7:0] r_grid_cols;
    logic       r_fill_all;

    // Ink map
    logic          r_map [DEPTH];
    logic          r_rdata;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic [AW-1:0] mem_raddr;

    // Control and cursor state
    t_state        r_state, n_state;
    logic [AW-1:0] r_clr, n_clr;
    t_pos          r_cur, n_cur;
    logic [HUE_W-1:0] r_hue, n_hue;
    t_pos          r_cand, n_cand;
    logic          r_cand_vld, n_cand_vld;
    t_res          r_pend, n_pend;
    t_res          r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic [CRD_W-1:0] eff_h, eff_w;
    t_pos          corner;
    t_step         nxt;
    logic          cur_in_grid;
    logic [CRD_W-1:0] ld_row, ld_col;
    logic          ld_in_store;
    logic          cfg_wr;

    function automatic logic [AW-1:0] addr_of(t_pos p);
        return {p.row[RW-1:0], p.col[CW-1:0]};
    endfunction

    function automatic t_pos start_pos(t_dir dir, logic [CRD_W-1:0] h, logic [CRD_W-1:0] w);
        t_pos q;
        unique case (dir) inside
            DIR_DIAG_TR, DIR_COLS_LEFT: begin
                q.row = '0;
                q.col = w - 8'd1;
            end
            DIR_DIAG_BR: begin
                q.row = h - 8'd1;
                q.col = w - 8'd1;
            end
            DIR_ROWS_UP, DIR_DIAG_BL: begin
                q.row = h - 8'd1;
                q.col = '0;
            end
            default: begin
                q.row = '0;
                q.col = '0;
            end
        endcase
        return q;
    endfunction

    // One step of the scan order from a cell inside the grid
    function automatic t_step step_pos(t_dir dir, logic [CRD_W-1:0] h,
                                       logic [CRD_W-1:0] w, t_pos p);
        logic [9:0] r, c, hh, ww, d, maxd;
        logic       wrap;
        t_step      s;
        r    = {2'b00, p.row};
        c    = {2'b00, p.col};
        hh   = {2'b00, h};
        ww   = {2'b00, w};
        maxd = hh + ww - 10'd2;
        wrap = 1'b0;
        d    = '0;
        unique case (dir)
            DIR_DIAG_TL: begin
                if (r < hh - 10'd1 && c > 10'd0) begin
                    r = r + 10'd1;
                    c = c - 10'd1;
                end else begin
                    d = r + c + 10'd1;
                    if (d > maxd) begin
                        wrap = 1'b1;
                    end else if (d < ww) begin
                        r = '0;
                        c = d;
                    end else begin
                        r = d - ww + 10'd1;
                        c = ww - 10'd1;
                    end
                end
            end
            DIR_ROWS_DOWN: begin
                c = c + 10'd1;
                if (c >= ww) begin
                    c = '0;
                    r = r + 10'd1;
                end
                if (r >= hh) wrap = 1'b1;
            end
            DIR_DIAG_TR: begin
                if (r < hh - 10'd1 && c < ww - 10'd1) begin
                    r = r + 10'd1;
                    c = c + 10'd1;
                end else begin
                    d = r + (ww - 10'd1 - c) + 10'd1;
                    if (d > maxd) begin
                        wrap = 1'b1;
                    end else if (d < ww) begin
                        r = '0;
                        c = ww - 10'd1 - d;
                    end else begin
                        r = d - ww + 10'd1;
                        c = '0;
                    end
                end
            end
            DIR_COLS_LEFT: begin
                r = r + 10'd1;
                if (r >= hh) begin
                    r = '0;
                    if (c == 10'd0) wrap = 1'b1;
                    else c = c - 10'd1;
                end
            end
            DIR_DIAG_BR: begin
                if (r > 10'd0 && c < ww - 10'd1) begin
                    r = r - 10'd1;
                    c = c + 10'd1;
                end else begin
                    d = (hh - 10'd1 - r) + (ww - 10'd1 - c) + 10'd1;
                    if (d > maxd) begin
                        wrap = 1'b1;
                    end else if (d < ww) begin
                        r = hh - 10'd1;
                        c = ww - 10'd1 - d;
                    end else begin
                        r = hh + ww - 10'd2 - d;
                        c = '0;
                    end
                end
            end
            DIR_ROWS_UP: begin
                c = c + 10'd1;
                if (c >= ww) begin
                    c = '0;
                    if (r == 10'd0) wrap = 1'b1;
                    else r = r - 10'd1;
                end
            end
            DIR_DIAG_BL: begin
                if (r > 10'd0 && c > 10'd0) begin
                    r = r - 10'd1;
                    c = c - 10'd1;
                end else begin
                    d = (hh - 10'd1 - r) + c + 10'd1;
                    if (d > maxd) begin
                        wrap = 1'b1;
                    end else if (d < ww) begin
                        r = hh - 10'd1;
                        c = d;
                    end else begin
                        r = hh + ww - 10'd2 - d;
                        c = ww - 10'd1;
                    end
                end
            end
            DIR_COLS_RIGHT: begin
                r = r + 10'd1;
                if (r >= hh) begin
                    r = '0;
                    c = c + 10'd1;
                end
                if (c >= ww) wrap = 1'b1;
            end
        endcase
        s.wrap    = wrap;
        s.pos.row = r[CRD_W-1:0];
        s.pos.col = c[CRD_W-1:0];
        return s;
    endfunction

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_DIAG_TL;
            r_grid_rows <= GRID_ROWS_RST;
            r_grid_cols <= GRID_COLS_RST;
            r_fill_all  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (t_reg'(paddr[3:2]))
                REG_DIR:  r_dir       <= t_dir'(pwdata[2:0]);
                REG_ROWS: r_grid_rows <= pwdata[6:0];
                REG_COLS: r_grid_cols <= pwdata[7:0];
                REG_FILL: r_fill_all  <= pwdata[0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (t_reg'(paddr[3:2]))
            REG_DIR:  prdata[2:0] = r_dir;
            REG_ROWS: prdata[6:0] = r_grid_rows;
            REG_COLS: prdata[7:0] = r_grid_cols;
            REG_FILL: prdata[0]   = r_fill_all;
        endcase
    end

    // Grid in use: zero acts as one, clamp to the store
    always_comb begin
        if (r_grid_rows == 7'd0) eff_h = 8'd1;
        else if ({2'b00, r_grid_rows} > MAXR9) eff_h = MAXR9[CRD_W-1:0];
        else eff_h = {1'b0, r_grid_rows};
        if (r_grid_cols == 8'd0) eff_w = 8'd1;
        else if ({1'b0, r_grid_cols} > MAXC9) eff_w = MAXC9[CRD_W-1:0];
        else eff_w = r_grid_cols;
    end

    assign corner      = start_pos(r_dir, eff_h, eff_w);
    assign nxt         = step_pos(r_dir, eff_h, eff_w, r_cand);
    assign cur_in_grid = (r_cur.row < eff_h) && (r_cur.col < eff_w);
    assign ld_row      = CRD_W'(i_req.cell_row);
    assign ld_col      = CRD_W'(i_req.cell_col);
    assign ld_in_store = ({1'b0, ld_row} < MAXR9) && ({1'b0, ld_col} < MAXC9);

    // Ink map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_map[mem_waddr] <= mem_wdata;
        r_rdata <= r_map[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr      <= '0;
            r_cur      <= '0;
            r_hue      <= '0;
            r_cand_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr      <= n_clr;
            r_cur      <= n_cur;
            r_hue      <= n_hue;
            r_cand_vld <= n_cand_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cand <= n_cand;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign i_req.ready = (r_state == ST_IDLE);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_cur      = r_cur;
        n_hue      = r_hue;
        n_cand     = r_cand;
        n_cand_vld = r_cand_vld;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !o_res.ready;
        mem_we     = 1'b0;
        mem_waddr  = addr_of('{row: ld_row, col: ld_col});
        mem_wdata  = i_req.cell_inked;
        mem_raddr  = addr_of(nxt.pos);

        unique case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = 1'b0;
                n_clr     = r_clr + AW'(1);
                if (r_clr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_req.valid) begin
                    n_pend  = '0;
                    n_state = ST_PUSH;
                    case (i_req.req_type)
                        REQ_LOAD: begin
                            mem_we = ld_in_store;
                        end
                        REQ_RESTART: begin
                            n_cur = corner;
                            n_hue = '0;
                        end
                        REQ_TICK: begin
                            if (!cur_in_grid) begin
                                n_cur = corner;
                            end else begin
                                n_pend.painted_valid = 1'b1;
                                n_pend.painted_row   = r_cur.row[ROW_W-1:0];
                                n_pend.painted_col   = r_cur.col[COL_W-1:0];
                                n_pend.painted_hue   = r_hue;
                                n_cand               = r_cur;
                                n_cand_vld           = 1'b0;
                                n_state              = ST_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                // r_rdata holds the ink bit of r_cand when r_cand_vld is set
                if (r_cand_vld && r_rdata) begin
                    n_cur   = r_cand;
                    n_state = ST_PUSH;
                end else if (nxt.wrap) begin
                    n_cur               = corner;
                    n_hue               = r_hue + 3'd1;
                    n_pend.scan_wrapped = 1'b1;
                    n_state             = ST_PUSH;
                end else if (r_fill_all) begin
                    n_cur   = nxt.pos;
                    n_state = ST_PUSH;
                end else begin
                    n_cand     = nxt.pos;
                    n_cand_vld = 1'b1;
                end
            end
            ST_PUSH: begin
                if (!r_out_vld || o_res.ready) begin
                    n_out            = r_pend;
                    n_out.cursor_row = r_cur.row[ROW_W-1:0];
                    n_out.cursor_col = r_cur.col[COL_W-1:0];
                    n_out_vld        = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
        endcase
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.painted_valid = r_out.painted_valid;
    assign o_res.painted_row   = r_out.painted_row;
    assign o_res.painted_col   = r_out.painted_col;
    assign o_res.painted_hue   = r_out.painted_hue;
    assign o_res.cursor_row    = r_out.cursor_row;
    assign o_res.cursor_col    = r_out.cursor_col;
    assign o_res.scan_wrapped  = r_out.scan_wrapped;

    // A result without paint reports zero paint fields
    a_nopaint_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.painted_valid) |->
        (o_res.painted_row == '0 && o_res.painted_col == '0 && o_res.painted_hue == '0))
        else $error("paint fields set on a result without paint");

    // Only a painting tick can wrap
    a_wrap_paints: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.scan_wrapped) |-> o_res.painted_valid)
        else $error("wrap reported without paint");

    // The map is never written in the scan state or the push state
    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN || r_state == ST_PUSH) |-> !mem_we)
        else $error("ink map written during scan");

    // The hue step moves only at a wrap or a restart
    a_hue_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_hue) |-> ($past(r_state) == ST_SCAN || $past(r_state) == ST_IDLE))
        else $error("hue step changed outside a scan or restart");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for directional_scan_cursor: directed and random request
// streams, with a cycle-free scan predictor and a checker on the result channel.
// Depends on dsc_pkg, dsc_req_if, dsc_res_if and the top level.
`timescale 1ns / 1ps

module tb_top;
    import dsc_pkg::*;

    localparam int MAX_R = MAX_ROWS_DEF;
    localparam int MAX_C = MAX_COLS_DEF;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    dsc_req_if req_if ();
    dsc_res_if res_if ();

    directional_scan_cursor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Scan predictor state and its register copies
    bit         ink_map [MAX_R][MAX_C];
    int         cur_r;
    int         cur_c;
    logic [2:0] hue_now;
    t_dir       cfg_dir;
    logic [6:0] cfg_rows;
    logic [7:0] cfg_cols;
    logic       cfg_fill;

    t_res paint_reports_q[$];
    int   mismatch_count;
    bit   idle_on;

    function automatic int rows_used();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_R) return MAX_R;
        return int'(cfg_rows);
    endfunction

    function automatic int cols_used();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > MAX_C) return MAX_C;
        return int'(cfg_cols);
    endfunction

    function automatic void start_corner(input int h, input int w, output int r, output int c);
        case (cfg_dir)
            DIR_DIAG_TR, DIR_COLS_LEFT: begin r = 0;     c = w - 1; end
            DIR_DIAG_BR:                begin r = h - 1; c = w - 1; end
            DIR_ROWS_UP, DIR_DIAG_BL:   begin r = h - 1; c = 0;     end
            default:                    begin r = 0;     c = 0;     end
        endcase
    endfunction

    // One cell along the current order; returns 1 when the scan ran off its end
    function automatic bit next_cell(input int h, input int w, inout int r, inout int c);
        int band;
        int last_band;
        bit wrap;
        last_band = h + w - 2;
        wrap = 1'b0;
        case (cfg_dir)
            DIR_DIAG_TL: begin
                if (r < h - 1 && c > 0) begin
                    r++; c--;
                end else begin
                    band = r + c + 1;
                    if (band > last_band) wrap = 1'b1;
                    else if (band < w) begin r = 0; c = band; end
                    else begin r = band - w + 1; c = w - 1; end
                end
            end
            DIR_ROWS_DOWN: begin
                c++;
                if (c >= w) begin c = 0; r++; end
                if (r >= h) wrap = 1'b1;
            end
            DIR_DIAG_TR: begin
                if (r < h - 1 && c < w - 1) begin
                    r++; c++;
                end else begin
                    band = r + (w - 1 - c) + 1;
                    if (band > last_band) wrap = 1'b1;
                    else if (band < w) begin r = 0; c = w - 1 - band; end
                    else begin r = band - w + 1; c = 0; end
                end
            end
            DIR_COLS_LEFT: begin
                r++;
                if (r >= h) begin r = 0; c--; end
                if (c < 0) wrap = 1'b1;
            end
            DIR_DIAG_BR: begin
                if (r > 0 && c < w - 1) begin
                    r--; c++;
                end else begin
                    band = (h - 1 - r) + (w - 1 - c) + 1;
                    if (band > last_band) wrap = 1'b1;
                    else if (band < w) begin r = h - 1; c = w - 1 - band; end
                    else begin r = h - 1 - (band - w + 1); c = 0; end
                end
            end
            DIR_ROWS_UP: begin
                c++;
                if (c >= w) begin c = 0; r--; end
                if (r < 0) wrap = 1'b1;
            end
            DIR_DIAG_BL: begin
                if (r > 0 && c > 0) begin
                    r--; c--;
                end else begin
                    band = (h - 1 - r) + c + 1;
                    if (band > last_band) wrap = 1'b1;
                    else if (band < w) begin r = h - 1; c = band; end
                    else begin r = h - 1 - (band - w + 1); c = w - 1; end
                end
            end
            default: begin
                r++;
                if (r >= h) begin r = 0; c++; end
                if (c >= w) wrap = 1'b1;
            end
        endcase
        if (wrap) start_corner(h, w, r, c);
        return wrap;
    endfunction

    function automatic t_res predict_paint(input logic [1:0] kind, input logic [5:0] row,
                                           input logic [6:0] col, input logic inked);
        t_res res;
        int   h;
        int   w;
        bit   wrap;
        res = '0;
        h = rows_used();
        w = cols_used();
        case (kind)
            REQ_LOAD: ink_map[row][col] = inked;
            REQ_RESTART: begin
                start_corner(h, w, cur_r, cur_c);
                hue_now = '0;
            end
            REQ_TICK: begin
                if (cur_r >= h || cur_c >= w) begin
                    // grid shrank under the cursor: jump home, no paint
                    start_corner(h, w, cur_r, cur_c);
                end else begin
                    res.painted_valid = 1'b1;
                    res.painted_row   = cur_r[ROW_W-1:0];
                    res.painted_col   = cur_c[COL_W-1:0];
                    res.painted_hue   = hue_now;
                    do
                        wrap = next_cell(h, w, cur_r, cur_c);
                    while (!wrap && !cfg_fill && !ink_map[cur_r][cur_c]);
                    if (wrap) begin
                        res.scan_wrapped = 1'b1;
                        hue_now = hue_now + 3'd1;
                    end
                end
            end
            default: ;
        endcase
        res.cursor_row = cur_r[ROW_W-1:0];
        res.cursor_col = cur_c[COL_W-1:0];
        return res;
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (i_rst_n === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            got.painted_valid = res_if.painted_valid;
            got.painted_row   = res_if.painted_row;
            got.painted_col   = res_if.painted_col;
            got.painted_hue   = res_if.painted_hue;
            got.cursor_row    = res_if.cursor_row;
            got.cursor_col    = res_if.cursor_col;
            got.scan_wrapped  = res_if.scan_wrapped;
            if (paint_reports_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with no request pending", $realtime);
            end else begin
                want = paint_reports_q.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("%0t: mismatch exp pv=%0d p=%0d,%0d hue=%0d cur=%0d,%0d wrap=%0d",
                               $realtime, want.painted_valid, want.painted_row,
                               want.painted_col, want.painted_hue, want.cursor_row,
                               want.cursor_col, want.scan_wrapped);
                        $display(" | got pv=%0d p=%0d,%0d hue=%0d cur=%0d,%0d wrap=%0d",
                                 got.painted_valid, got.painted_row, got.painted_col,
                                 got.painted_hue, got.cursor_row, got.cursor_col,
                                 got.scan_wrapped);
                    end
                end
            end
        end
    end

    // Result-side backpressure in short bursts
    initial begin
        int n;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                res_if.ready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_req(input logic [1:0] kind, input int row, input int col,
                            input bit inked);
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        req_if.valid      <= 1'b1;
        req_if.req_type   <= kind;
        req_if.cell_row   <= row[ROW_W-1:0];
        req_if.cell_col   <= col[COL_W-1:0];
        req_if.cell_inked <= inked;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        paint_reports_q.push_back(predict_paint(kind, row[ROW_W-1:0], col[COL_W-1:0], inked));
    endtask

    // Drop the request line and let every pending request come back
    task automatic wait_quiet();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (paint_reports_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input t_reg idx, input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        case (idx)
            REG_DIR:  cfg_dir  = t_dir'(data[2:0]);
            REG_ROWS: cfg_rows = data[6:0];
            REG_COLS: cfg_cols = data[7:0];
            default:  cfg_fill = data[0];
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input t_dir dir, input int rows, input int cols, input bit fill);
        wait_quiet();
        apb_write(REG_DIR, PDATA_W'(dir));
        apb_write(REG_ROWS, PDATA_W'(rows));
        apb_write(REG_COLS, PDATA_W'(cols));
        apb_write(REG_FILL, PDATA_W'(fill));
    endtask

    // Reset defaults: unused request, then a tick that skips the whole blank grid
    task automatic test_reset_scan();
        send_req(REQ_UNUSED, 63, 127, 1'b1);
        send_req(REQ_TICK, 0, 0, 1'b0);
    endtask

    task automatic test_corner_extremes();
        send_req(REQ_LOAD, 63, 127, 1'b1);
        send_req(REQ_LOAD, 0, 0, 1'b1);
        send_req(REQ_LOAD, 63, 127, 1'b0);
        configure(DIR_DIAG_BR, 64, 128, 1'b1);
        send_req(REQ_RESTART, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
    endtask

    // Cursor left outside after the grid shrinks
    task automatic test_cursor_outside();
        configure(DIR_DIAG_BR, 4, 4, 1'b1);
        send_req(REQ_TICK, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
    endtask

    // Zero sizes act as 1x1, oversize values clamp to the store
    task automatic test_degenerate_grid();
        configure(DIR_DIAG_TL, 0, 0, 1'b0);
        send_req(REQ_RESTART, 0, 0, 1'b0);
        repeat (3) send_req(REQ_TICK, 0, 0, 1'b0);
        configure(DIR_COLS_RIGHT, 127, 255, 1'b1);
        send_req(REQ_RESTART, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
    endtask

    // New direction continues from the current cell; restart goes to the new corner
    task automatic test_direction_change();
        configure(DIR_DIAG_TL, 5, 6, 1'b0);
        send_req(REQ_LOAD, 1, 0, 1'b1);
        send_req(REQ_LOAD, 2, 3, 1'b1);
        send_req(REQ_RESTART, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
        configure(DIR_DIAG_BL, 5, 6, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
        send_req(REQ_TICK, 0, 0, 1'b0);
        send_req(REQ_RESTART, 0, 0, 1'b0);
    endtask

    task automatic run_scan_phase(input int n_items);
        int rows;
        int cols;
        int h;
        int w;
        int pick;
        int row;
        int col;
        logic [1:0] kind;
        // mostly small grids so blank skips stay short
        pick = $urandom_range(0, 9);
        rows = (pick < 7) ? $urandom_range(1, 8) : (pick == 7) ? 0 : $urandom_range(0, 127);
        pick = $urandom_range(0, 9);
        cols = (pick < 7) ? $urandom_range(1, 8) : (pick == 7) ? 0 : $urandom_range(0, 255);
        configure(t_dir'($urandom_range(0, 7)), rows, cols, $urandom_range(0, 1));
        h = rows_used();
        w = cols_used();
        if ($urandom_range(0, 3) != 0) send_req(REQ_RESTART, 0, 0, 1'b0);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (i < 3 || (pick >= 55 && pick < 85)) kind = REQ_LOAD;
            else if (pick < 55) kind = REQ_TICK;
            else if (pick < 95) kind = REQ_RESTART;
            else kind = REQ_UNUSED;
            row = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, h - 1);
            col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, w - 1);
            send_req(kind, row, col, $urandom_range(0, 9) < 7);
        end
    endtask

    task automatic test_random_scans();
        for (int p = 0; p < 8; p++) begin
            idle_on = (p < 6) && ($urandom_range(0, 3) != 0);
            run_scan_phase($urandom_range(6, 10));
        end
    endtask

    initial begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        req_if.valid      = 1'b0;
        req_if.req_type   = REQ_LOAD;
        req_if.cell_row   = '0;
        req_if.cell_col   = '0;
        req_if.cell_inked = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        i_rst_n = 1'b0;
        mismatch_count = 0;
        idle_on  = 1'b1;
        cur_r    = 0;
        cur_c    = 0;
        hue_now  = '0;
        cfg_dir  = DIR_DIAG_TL;
        cfg_rows = GRID_ROWS_RST;
        cfg_cols = GRID_COLS_RST;
        cfg_fill = 1'b0;
        foreach (ink_map[r, c]) ink_map[r][c] = 1'b0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_scan();
        test_corner_extremes();
        test_cursor_outside();
        test_degenerate_grid();
        test_direction_change();
        test_random_scans();

        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && paint_reports_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/dsc_pkg.sv
design/dsc_req_if.sv
design/dsc_res_if.sv
design/directional_scan_cursor.sv
tb/tb_top.sv
